/* rtl/i2cs_pkg.sv */
// Shared types and codes for the I2C master transaction sequencer.
// Used by i2cs_store, i2cs_ctrl, the top level and the testbench; depends on nothing else.
package i2cs_pkg;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_STEP  = 2'd2,
    REQ_CONT  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    MODE_WR_ONLY   = 3'd0,
    MODE_RD_ONLY   = 3'd1,
    MODE_WR_RD     = 3'd2,
    MODE_STR_RD    = 3'd3,
    MODE_STR_WR_RD = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_RESTART = 3'd2,
    ACT_STOP    = 3'd3,
    ACT_SEND    = 3'd4,
    ACT_RECV    = 3'd5,
    ACT_ACK     = 3'd6
  } act_t;

  typedef enum logic [3:0] {
    PH_IDLE         = 4'd0,
    PH_START_WAIT   = 4'd1,
    PH_ADDR1_WAIT   = 4'd2,
    PH_DATA_WAIT    = 4'd3,
    PH_RESTART_WAIT = 4'd4,
    PH_ADDR2_WAIT   = 4'd5,
    PH_RX_WAIT      = 4'd6,
    PH_PAUSE        = 4'd7,
    PH_ACK_WAIT     = 4'd8,
    PH_STOP_WAIT    = 4'd9
  } phase_t;

  // One result item as it travels from the controller to the output register.
  typedef struct packed {
    act_t       action;
    logic [7:0] tx_byte;
    logic       ack_bit;
    logic       rx_valid;
    logic [7:0] rx_out;
    logic [7:0] rx_index;
    logic       stream_pause;
    logic       done_res;
    logic       busy_res;
  } res_t;

endpackage

/* rtl/i2cs_store.sv */
// Write-byte store of the I2C master transaction sequencer.
// One write port for loads, one registered read port; depends on i2cs_pkg.
module i2cs_store
  import i2cs_pkg::*;
#(
  parameter int WRITE_DEPTH = 16,
  parameter int IDX_W       = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  logic [7:0] mem_r [WRITE_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // The read address is the cursor value for the next cycle, so the output
  // always shows the slot under the cursor. A write to that slot in the same
  // cycle is forwarded.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/i2cs_ctrl.sv */
// Transaction state machine of the I2C master transaction sequencer.
// Holds phase, mode, address and counters and forms one result per request;
// depends on i2cs_pkg.
module i2cs_ctrl
  import i2cs_pkg::*;
#(
  parameter int WRITE_DEPTH = 16,
  parameter int CNT_W       = 5,
  parameter int IDX_W       = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [1:0]       req_type,
  input  logic [2:0]       mode,
  input  logic [6:0]       addr,
  input  logic [4:0]       write_len,
  input  logic [7:0]       read_len,
  input  logic             ack_status,
  input  logic [7:0]       rx_byte,
  input  logic             force_end,
  input  logic [7:0]       store_byte,
  output logic [IDX_W-1:0] store_addr,
  output res_t             res
);

  localparam logic [8:0] DEPTH9 = 9'(WRITE_DEPTH);

  phase_t           phase_r, phase_nxt;
  logic [2:0]       mode_r, mode_nxt;
  logic [6:0]       addr_r, addr_nxt;
  logic [CNT_W-1:0] wr_count_r, wr_count_nxt;
  logic [CNT_W-1:0] wr_cursor_r, wr_cursor_nxt;
  logic [7:0]       rd_count_r, rd_count_nxt;
  logic [7:0]       rd_cursor_r, rd_cursor_nxt;
  logic             rd_end_r, rd_end_nxt;

  logic             read_only;
  logic             stream;
  logic             wr_done;
  logic             last_rx;
  logic [8:0]       wlen9;
  logic [8:0]       wlen_cl;
  logic [7:0]       rlen_cl;
  logic             start_ok;
  phase_t           phase_calc;

  assign read_only = (mode_r == MODE_RD_ONLY) || (mode_r == MODE_STR_RD);
  assign stream    = (mode_r == MODE_STR_RD) || (mode_r == MODE_STR_WR_RD);
  assign wr_done   = (wr_cursor_r >= wr_count_r);
  assign last_rx   = (({1'b0, rd_cursor_r} + 9'd1) >= {1'b0, rd_count_r});
  assign start_ok  = (phase_r == PH_IDLE) && (mode <= MODE_STR_WR_RD);

  always_comb begin
    wlen9   = {4'd0, write_len};
    wlen_cl = wlen9;
    if (wlen9 == 9'd0) begin
      wlen_cl = 9'd1;
    end else if (wlen9 > DEPTH9) begin
      wlen_cl = DEPTH9;
    end
    rlen_cl = (read_len == 8'd0) ? 8'd1 : read_len;
  end

  // Next-state logic for all registers, as if the request is accepted.
  always_comb begin
    phase_calc    = phase_r;
    mode_nxt      = mode_r;
    addr_nxt      = addr_r;
    wr_count_nxt  = wr_count_r;
    wr_cursor_nxt = wr_cursor_r;
    rd_count_nxt  = rd_count_r;
    rd_cursor_nxt = rd_cursor_r;
    rd_end_nxt    = rd_end_r;
    case (req_type)
      REQ_START: begin
        if (start_ok) begin
          mode_nxt      = mode;
          addr_nxt      = addr;
          wr_count_nxt  = CNT_W'(wlen_cl);
          wr_cursor_nxt = '0;
          rd_count_nxt  = rlen_cl;
          rd_cursor_nxt = 8'd0;
          rd_end_nxt    = 1'b0;
          phase_calc    = PH_START_WAIT;
        end
      end
      REQ_STEP: begin
        case (phase_r)
          PH_START_WAIT: phase_calc = PH_ADDR1_WAIT;
          PH_ADDR1_WAIT: begin
            if (ack_status) begin
              phase_calc = PH_START_WAIT;
            end else if (read_only) begin
              phase_calc = PH_RX_WAIT;
            end else begin
              wr_cursor_nxt = wr_cursor_r + CNT_W'(1);
              phase_calc    = PH_DATA_WAIT;
            end
          end
          PH_DATA_WAIT: begin
            if (wr_done) begin
              phase_calc = (mode_r == MODE_WR_ONLY) ? PH_STOP_WAIT : PH_RESTART_WAIT;
            end else begin
              wr_cursor_nxt = wr_cursor_r + CNT_W'(1);
            end
          end
          PH_RESTART_WAIT: phase_calc = PH_ADDR2_WAIT;
          PH_ADDR2_WAIT: phase_calc = ack_status ? PH_RESTART_WAIT : PH_RX_WAIT;
          PH_RX_WAIT: begin
            rd_end_nxt    = last_rx;
            rd_cursor_nxt = rd_cursor_r + 8'd1;
            phase_calc    = stream ? PH_PAUSE : PH_ACK_WAIT;
          end
          PH_ACK_WAIT: phase_calc = rd_end_r ? PH_STOP_WAIT : PH_RX_WAIT;
          PH_STOP_WAIT: phase_calc = PH_IDLE;
          default: phase_calc = phase_r;
        endcase
      end
      REQ_CONT: begin
        if (phase_r == PH_PAUSE) begin
          rd_end_nxt = rd_end_r | force_end;
          phase_calc = PH_ACK_WAIT;
        end
      end
      default: phase_calc = phase_r;
    endcase
    phase_nxt = phase_calc;
  end

  // Result of the request, formed from the current state and the request.
  always_comb begin
    res          = '0;
    res.action   = ACT_NONE;
    res.busy_res = (phase_calc != PH_IDLE);
    case (req_type)
      REQ_START: begin
        if (start_ok) begin
          res.action = ACT_START;
        end
      end
      REQ_STEP: begin
        case (phase_r)
          PH_START_WAIT: begin
            res.action  = ACT_SEND;
            res.tx_byte = {addr_r, read_only};
          end
          PH_ADDR1_WAIT: begin
            if (ack_status) begin
              res.action = ACT_START;
            end else if (read_only) begin
              res.action = ACT_RECV;
            end else begin
              res.action  = ACT_SEND;
              res.tx_byte = store_byte;
            end
          end
          PH_DATA_WAIT: begin
            if (wr_done) begin
              res.action = (mode_r == MODE_WR_ONLY) ? ACT_STOP : ACT_RESTART;
            end else begin
              res.action  = ACT_SEND;
              res.tx_byte = store_byte;
            end
          end
          PH_RESTART_WAIT: begin
            res.action  = ACT_SEND;
            res.tx_byte = {addr_r, 1'b1};
          end
          PH_ADDR2_WAIT: res.action = ack_status ? ACT_RESTART : ACT_RECV;
          PH_RX_WAIT: begin
            res.rx_valid = 1'b1;
            res.rx_out   = rx_byte;
            res.rx_index = rd_cursor_r;
            if (stream) begin
              res.stream_pause = 1'b1;
            end else begin
              res.action  = ACT_ACK;
              res.ack_bit = last_rx;
            end
          end
          PH_ACK_WAIT: res.action = rd_end_r ? ACT_STOP : ACT_RECV;
          PH_STOP_WAIT: res.done_res = 1'b1;
          default: res.action = ACT_NONE;
        endcase
      end
      REQ_CONT: begin
        if (phase_r == PH_PAUSE) begin
          res.action  = ACT_ACK;
          res.ack_bit = rd_end_r | force_end;
        end
      end
      default: res.action = ACT_NONE;
    endcase
  end

  // The store prefetches the slot under the cursor of the coming cycle.
  assign store_addr = accept ? wr_cursor_nxt[IDX_W-1:0] : wr_cursor_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      mode_r      <= 3'd0;
      addr_r      <= 7'd0;
      wr_count_r  <= '0;
      wr_cursor_r <= '0;
      rd_count_r  <= 8'd0;
      rd_cursor_r <= 8'd0;
      rd_end_r    <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      mode_r      <= mode_nxt;
      addr_r      <= addr_nxt;
      wr_count_r  <= wr_count_nxt;
      wr_cursor_r <= wr_cursor_nxt;
      rd_count_r  <= rd_count_nxt;
      rd_cursor_r <= rd_cursor_nxt;
      rd_end_r    <= rd_end_nxt;
    end
  end

endmodule

/* rtl/i2c_master_transaction_sequencer.sv */
// Top level of the I2C master transaction sequencer.
// Instantiates i2cs_store and i2cs_ctrl and holds the result register;
// depends on i2cs_pkg.
//
//   Channel   Direction  Handshake             Moves
//   in_*      input      in_valid / in_ready   one request (start, load, step, continue)
//   out_*     output     out_valid / out_ready one result per request
//
// Every request gives exactly one result in the result register in the cycle
// after it is taken; a new request can be taken every cycle unless the output stalls.
// The rate is set by the state machine in i2cs_ctrl, whose next state and
// result are formed in one pass from the request and the registered state.
// in_ready is high whenever the result register is empty or is being drained
// in the same cycle, so a stalled output holds back only new requests.
// Reset (rst_n low, synchronous) returns the block to idle and empties the
// result register; the write-byte store is not cleared and holds whatever was
// loaded.
//
// The write store is a small memory with a registered read port that is
// always addressed with the write cursor of the coming cycle, so the byte
// under the cursor is ready when a data step arrives. Bytes are loaded at any
// time; a load whose slot lies beyond the store depth is dropped.
module i2c_master_transaction_sequencer
  import i2cs_pkg::*;
#(
  parameter int WRITE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [2:0] in_mode,
  input  logic [6:0] in_addr,
  input  logic [4:0] in_write_len,
  input  logic [7:0] in_read_len,
  input  logic [3:0] in_load_index,
  input  logic [7:0] in_load_byte,
  input  logic       in_ack_status,
  input  logic [7:0] in_rx_byte,
  input  logic       in_force_end,

  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_action,
  output logic [7:0] out_tx_byte,
  output logic       out_ack_bit,
  output logic       out_rx_valid,
  output logic [7:0] out_rx_out,
  output logic [7:0] out_rx_index,
  output logic       out_stream_pause,
  output logic       out_done_res,
  output logic       out_busy_res
);

  // The cursor must reach the depth itself; the store index only has to reach depth - 1.
  localparam int CNT_W = $clog2(WRITE_DEPTH + 1);
  localparam int IDX_W = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;

  logic             accept;
  logic             load_en;
  logic [IDX_W+3:0] load_idx_wide;
  logic [IDX_W-1:0] store_addr;
  logic [7:0]       store_byte;
  res_t             res;
  res_t             res_r;
  logic             out_valid_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // A load is taken in any phase, but only for a slot inside the store.
  assign load_idx_wide = {{IDX_W{1'b0}}, in_load_index};
  assign load_en = accept && (in_req_type == REQ_LOAD) &&
                   (32'(in_load_index) < 32'(WRITE_DEPTH));

  i2cs_store #(
    .WRITE_DEPTH (WRITE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (load_idx_wide[IDX_W-1:0]),
    .wr_data (in_load_byte),
    .rd_addr (store_addr),
    .rd_data (store_byte)
  );

  i2cs_ctrl #(
    .WRITE_DEPTH (WRITE_DEPTH),
    .CNT_W       (CNT_W),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .req_type   (in_req_type),
    .mode       (in_mode),
    .addr       (in_addr),
    .write_len  (in_write_len),
    .read_len   (in_read_len),
    .ack_status (in_ack_status),
    .rx_byte    (in_rx_byte),
    .force_end  (in_force_end),
    .store_byte (store_byte),
    .store_addr (store_addr),
    .res        (res)
  );

  // Result register: filled on every accepted request, emptied when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = res_r.action;
  assign out_tx_byte      = res_r.tx_byte;
  assign out_ack_bit      = res_r.ack_bit;
  assign out_rx_valid     = res_r.rx_valid;
  assign out_rx_out       = res_r.rx_out;
  assign out_rx_index     = res_r.rx_index;
  assign out_stream_pause = res_r.stream_pause;
  assign out_done_res     = res_r.done_res;
  assign out_busy_res     = res_r.busy_res;

endmodule

/* dv/i2c_master_transaction_sequencer_tb.sv */
// Self-checking testbench for the I2C master transaction sequencer: random
// and directed requests, a per-request predictor and a result scoreboard.
// Depends on i2cs_pkg and the i2c_master_transaction_sequencer top level.
module i2c_master_transaction_sequencer_tb;
  import i2cs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH  = 16;
  localparam int USEFUL_ITEMS = 950;
  // No legal run goes this many cycles without a handshake on either side:
  // the longest request gap and result stall drawn by draw_gap are far shorter.
  localparam int STALL_LIMIT  = 2000;

  // One request as the driver presents it. The mode stays a raw vector so
  // that the unsupported codes can be sent as well.
  typedef struct {
    req_t       req;
    logic [2:0] mode;
    logic [6:0] addr;
    logic [4:0] wlen;
    logic [7:0] rlen;
    logic [3:0] lidx;
    logic [7:0] lbyte;
    logic       nack;
    logic [7:0] rxb;
    logic       fend;
  } req_item_t;

  // Everything the sequencer remembers between requests.
  typedef struct {
    phase_t     phase;
    mode_t      mode;
    logic [6:0] addr;
    logic [7:0] store [STORE_DEPTH];
    logic [4:0] wcount;
    logic [4:0] wcursor;
    logic [7:0] rcount;
    logic [7:0] rcursor;
    logic       rend;
  } seq_state_t;

  logic       clk;
  logic       rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_req_type = '0;
  logic [2:0] in_mode = '0;
  logic [6:0] in_addr = '0;
  logic [4:0] in_write_len = '0;
  logic [7:0] in_read_len = '0;
  logic [3:0] in_load_index = '0;
  logic [7:0] in_load_byte = '0;
  logic       in_ack_status = 1'b0;
  logic [7:0] in_rx_byte = '0;
  logic       in_force_end = 1'b0;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_action;
  logic [7:0] out_tx_byte;
  logic       out_ack_bit;
  logic       out_rx_valid;
  logic [7:0] out_rx_out;
  logic [7:0] out_rx_index;
  logic       out_stream_pause;
  logic       out_done_res;
  logic       out_busy_res;

  req_item_t  pend_q[$];     // requests still to be driven
  res_t       bus_step_q[$]; // predicted results, oldest first
  req_item_t  cur_req;       // request currently on the input port

  seq_state_t gen_st;        // state seen by the stimulus generator
  seq_state_t chk_st;        // state seen by the checker

  int         n_total = 0;
  int         n_taken = 0;
  int         err_count = 0;
  int         gap_left = 0;
  int         hold_left = 0;
  int         in_calm = 0;
  int         out_calm = 0;
  logic       in_fire_seen = 1'b0;
  logic       out_fire_seen = 1'b0;

  i2c_master_transaction_sequencer #(
    .WRITE_DEPTH(STORE_DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_mode          (in_mode),
    .in_addr          (in_addr),
    .in_write_len     (in_write_len),
    .in_read_len      (in_read_len),
    .in_load_index    (in_load_index),
    .in_load_byte     (in_load_byte),
    .in_ack_status    (in_ack_status),
    .in_rx_byte       (in_rx_byte),
    .in_force_end     (in_force_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_action       (out_action),
    .out_tx_byte      (out_tx_byte),
    .out_ack_bit      (out_ack_bit),
    .out_rx_valid     (out_rx_valid),
    .out_rx_out       (out_rx_out),
    .out_rx_index     (out_rx_index),
    .out_stream_pause (out_stream_pause),
    .out_done_res     (out_done_res),
    .out_busy_res     (out_busy_res)
  );

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic seq_state_t idle_state();
    seq_state_t st;
    st.phase   = PH_IDLE;
    st.mode    = MODE_WR_ONLY;
    st.addr    = '0;
    st.store   = '{default: 8'h00};
    st.wcount  = '0;
    st.wcursor = '0;
    st.rcount  = '0;
    st.rcursor = '0;
    st.rend    = 1'b0;
    return st;
  endfunction

  // Fetches the write byte under the cursor and moves the cursor on.
  function automatic logic [7:0] next_write_byte(ref seq_state_t st);
    logic [7:0] b;
    b = 8'h00;
    if (st.wcursor < STORE_DEPTH) begin
      b = st.store[st.wcursor];
    end
    st.wcursor = st.wcursor + 5'd1;
    return b;
  endfunction

  // Applies one request to the state and returns the result it produces.
  function automatic res_t step_sequencer(ref seq_state_t st, input req_item_t it);
    res_t       r;
    logic       rd_only;
    logic       stream;
    logic [4:0] wl;
    logic [7:0] rl;
    r = '0;
    r.action = ACT_NONE;
    rd_only = (st.mode == MODE_RD_ONLY) || (st.mode == MODE_STR_RD);
    stream  = (st.mode == MODE_STR_RD) || (st.mode == MODE_STR_WR_RD);
    case (it.req)
      REQ_START: begin
        // A start while busy or with an unsupported mode is dropped.
        if (st.phase == PH_IDLE && it.mode <= MODE_STR_WR_RD) begin
          wl = it.wlen;
          if (wl == 5'd0) wl = 5'd1;
          if (wl > STORE_DEPTH) wl = 5'(STORE_DEPTH);
          rl = it.rlen;
          if (rl == 8'd0) rl = 8'd1;
          st.mode    = mode_t'(it.mode);
          st.addr    = it.addr;
          st.wcount  = wl;
          st.wcursor = '0;
          st.rcount  = rl;
          st.rcursor = '0;
          st.rend    = 1'b0;
          st.phase   = PH_START_WAIT;
          r.action   = ACT_START;
        end
      end
      REQ_LOAD: begin
        if (it.lidx < STORE_DEPTH) begin
          st.store[it.lidx] = it.lbyte;
        end
      end
      REQ_STEP: begin
        case (st.phase)
          PH_START_WAIT: begin
            r.action  = ACT_SEND;
            r.tx_byte = {st.addr, rd_only};
            st.phase  = PH_ADDR1_WAIT;
          end
          PH_ADDR1_WAIT: begin
            if (it.nack) begin
              r.action = ACT_START;
              st.phase = PH_START_WAIT;
            end else if (rd_only) begin
              r.action = ACT_RECV;
              st.phase = PH_RX_WAIT;
            end else begin
              r.action  = ACT_SEND;
              r.tx_byte = next_write_byte(st);
              st.phase  = PH_DATA_WAIT;
            end
          end
          PH_DATA_WAIT: begin
            // A NACK on a data byte does not stop the write.
            if (st.wcursor >= st.wcount) begin
              if (st.mode == MODE_WR_ONLY) begin
                r.action = ACT_STOP;
                st.phase = PH_STOP_WAIT;
              end else begin
                r.action = ACT_RESTART;
                st.phase = PH_RESTART_WAIT;
              end
            end else begin
              r.action  = ACT_SEND;
              r.tx_byte = next_write_byte(st);
            end
          end
          PH_RESTART_WAIT: begin
            r.action  = ACT_SEND;
            r.tx_byte = {st.addr, 1'b1};
            st.phase  = PH_ADDR2_WAIT;
          end
          PH_ADDR2_WAIT: begin
            if (it.nack) begin
              r.action = ACT_RESTART;
              st.phase = PH_RESTART_WAIT;
            end else begin
              r.action = ACT_RECV;
              st.phase = PH_RX_WAIT;
            end
          end
          PH_RX_WAIT: begin
            st.rend    = (9'(st.rcursor) + 9'd1 >= 9'(st.rcount));
            r.rx_valid = 1'b1;
            r.rx_out   = it.rxb;
            r.rx_index = st.rcursor;
            st.rcursor = st.rcursor + 8'd1;
            if (stream) begin
              r.stream_pause = 1'b1;
              st.phase = PH_PAUSE;
            end else begin
              r.action  = ACT_ACK;
              r.ack_bit = st.rend;
              st.phase  = PH_ACK_WAIT;
            end
          end
          PH_ACK_WAIT: begin
            if (st.rend) begin
              r.action = ACT_STOP;
              st.phase = PH_STOP_WAIT;
            end else begin
              r.action = ACT_RECV;
              st.phase = PH_RX_WAIT;
            end
          end
          PH_STOP_WAIT: begin
            r.done_res = 1'b1;
            st.phase   = PH_IDLE;
          end
          default: begin
            // Idle or paused: a bus completion means nothing here.
          end
        endcase
      end
      REQ_CONT: begin
        if (st.phase == PH_PAUSE) begin
          if (it.fend) st.rend = 1'b1;
          r.action  = ACT_ACK;
          r.ack_bit = st.rend;
          st.phase  = PH_ACK_WAIT;
        end
      end
      default: begin
      end
    endcase
    r.busy_res = (st.phase != PH_IDLE);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Every field is random; callers override the ones the request uses.
  function automatic req_item_t rand_item(req_t kind);
    req_item_t it;
    it.req   = kind;
    it.mode  = 3'($urandom);
    it.addr  = 7'($urandom);
    it.wlen  = 5'($urandom);
    it.rlen  = 8'($urandom);
    it.lidx  = 4'($urandom);
    it.lbyte = 8'($urandom);
    it.nack  = 1'($urandom);
    it.rxb   = 8'($urandom);
    it.fend  = 1'($urandom);
    return it;
  endfunction

  // The generator keeps its own copy of the state so that it knows which
  // request the sequencer is waiting for next.
  task automatic queue_request(input req_item_t it);
    pend_q.push_back(it);
    n_total++;
    void'(step_sequencer(gen_st, it));
  endtask

  // Mostly short gaps, a few long ones, and now and then a run of requests
  // or results with no gap at all.
  function automatic int draw_gap(ref int calm_run);
    int r;
    if (calm_run > 0) begin
      calm_run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_run = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  initial begin
    req_item_t it;
    int        n_useful;
    int        r;
    gen_st = idle_state();
    chk_st = idle_state();

    // Fill every store slot first, so that no transaction can ever read a
    // slot that was never loaded. The first two carry the byte extremes.
    for (int i = 0; i < STORE_DEPTH; i++) begin
      it = rand_item(REQ_LOAD);
      it.lidx = 4'(i);
      if (i == 0) it.lbyte = 8'h00;
      if (i == 1) it.lbyte = 8'hFF;
      queue_request(it);
    end

    // Requests that an idle sequencer must drop.
    it = rand_item(REQ_START);
    it.mode = 3'd7;
    it.addr = 7'd0;
    queue_request(it);
    queue_request(rand_item(REQ_STEP));
    queue_request(rand_item(REQ_CONT));

    // A single-byte write to the top address with both lengths zero, which
    // count as one, and a second start that arrives while it is busy.
    it = rand_item(REQ_START);
    it.mode = MODE_WR_ONLY;
    it.addr = 7'h7F;
    it.wlen = 5'd0;
    it.rlen = 8'd0;
    queue_request(it);
    it = rand_item(REQ_START);
    it.mode = MODE_RD_ONLY;
    queue_request(it);
    for (int i = 0; i < 4; i++) begin
      it = rand_item(REQ_STEP);
      it.nack = 1'b0;
      queue_request(it);
    end

    // Random part: mostly the request the sequencer is waiting for, with
    // random content, plus some noise of any kind at any phase.
    n_useful = 0;
    while (n_useful < USEFUL_ITEMS) begin
      if ($urandom_range(0, 99) < 12) begin
        queue_request(rand_item(req_t'($urandom_range(0, 3))));
      end else begin
        case (gen_st.phase)
          PH_IDLE: begin
            it = rand_item(REQ_START);
            it.mode = ($urandom_range(0, 9) != 0) ? 3'($urandom_range(0, 4))
                                                  : 3'($urandom_range(5, 7));
            r = $urandom_range(0, 99);
            if (r < 10) it.wlen = 5'd0;
            else if (r < 70) it.wlen = 5'($urandom_range(1, 4));
            else if (r < 85) it.wlen = 5'($urandom_range(5, 16));
            else it.wlen = 5'($urandom_range(17, 31));
            // Long reads are rare; they are what drives the top index bits.
            r = $urandom_range(0, 99);
            if (r < 8) it.rlen = 8'd0;
            else if (r < 80) it.rlen = 8'($urandom_range(1, 6));
            else if (r < 97) it.rlen = 8'($urandom_range(7, 20));
            else it.rlen = 8'($urandom_range(0, 255));
          end
          PH_PAUSE: begin
            it = rand_item(REQ_CONT);
            it.fend = ($urandom_range(0, 9) == 0);
          end
          default: begin
            it = rand_item(REQ_STEP);
            it.nack = ($urandom_range(0, 9) == 0);
          end
        endcase
        queue_request(it);
        n_useful++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Clock, reset and run control
  // ---------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Request driver: a request stays on the port until it is taken, then
  // the next one follows after a random gap.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire_seen) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (pend_q.size() != 0) begin
        cur_req = pend_q.pop_front();
        in_req_type   <= cur_req.req;
        in_mode       <= cur_req.mode;
        in_addr       <= cur_req.addr;
        in_write_len  <= cur_req.wlen;
        in_read_len   <= cur_req.rlen;
        in_load_index <= cur_req.lidx;
        in_load_byte  <= cur_req.lbyte;
        in_ack_status <= cur_req.nack;
        in_rx_byte    <= cur_req.rxb;
        in_force_end  <= cur_req.fend;
        in_valid      <= 1'b1;
        gap_left = draw_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink: after each result taken it may stall for a while.
  always @(negedge clk) begin
    int g;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (out_fire_seen) begin
      g = draw_gap(out_calm);
      if (g > 0) begin
        out_ready <= 1'b0;
        hold_left = g - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      err_count++;
    end
  endtask

  // Scoreboard: every taken request is predicted at the edge that takes it;
  // every taken result is checked against the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    in_fire_seen  <= rst_n && in_valid && in_ready;
    out_fire_seen <= rst_n && out_valid && out_ready;
    if (rst_n && out_valid && out_ready) begin
      if (bus_step_q.size() == 0) begin
        $error("result with no request pending: action %0d", out_action);
        err_count++;
      end else begin
        want = bus_step_q.pop_front();
        check_field("action", want.action, out_action);
        check_field("tx_byte", want.tx_byte, out_tx_byte);
        check_field("ack_bit", want.ack_bit, out_ack_bit);
        check_field("rx_valid", want.rx_valid, out_rx_valid);
        check_field("rx_out", want.rx_out, out_rx_out);
        check_field("rx_index", want.rx_index, out_rx_index);
        check_field("stream_pause", want.stream_pause, out_stream_pause);
        check_field("done_res", want.done_res, out_done_res);
        check_field("busy_res", want.busy_res, out_busy_res);
      end
    end
    if (rst_n && in_valid && in_ready) begin
      bus_step_q.push_back(step_sequencer(chk_st, cur_req));
      n_taken++;
    end
  end

  // Watchdog: too long without any handshake on either channel.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(negedge clk);
      if (in_fire_seen || out_fire_seen) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("i2c_master_transaction_sequencer test failed");
    $finish;
  end

  // Normal end: all requests taken, all results in, then a short drain so
  // that a stray extra result would still be caught.
  initial begin
    do begin
      @(negedge clk);
    end while (n_total == 0 || n_taken != n_total || bus_step_q.size() != 0);
    repeat (10) @(negedge clk);
    if (err_count == 0) begin
      $display("i2c_master_transaction_sequencer test passed");
    end else begin
      $display("i2c_master_transaction_sequencer test failed");
    end
    $finish;
  end

endmodule
